[rtl/core/gelu_pkg.sv]
// Package with the constants, widths and activation lookup tables of the GELU core.
package gelu_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int FRAC_BITS      = 12;
    localparam int TABLE_SEGMENTS = 64;

    localparam int SEG_BITS     = $clog2(TABLE_SEGMENTS);
    localparam int ZF           = 16;
    localparam int Z_LIMIT_BITS = 19;
    localparam int REM_SHIFT    = Z_LIMIT_BITS - SEG_BITS;
    localparam int TAB_W        = ZF + 1;
    localparam int IDX_W        = SEG_BITS + 1;

    localparam int A_W    = DATA_WIDTH;
    localparam int XW     = A_W + ZF;
    localparam int AM_SHL = (FRAC_BITS <= ZF) ? (ZF - FRAC_BITS) : 0;
    localparam int AM_SHR = (FRAC_BITS > ZF) ? (FRAC_BITS - ZF) : 0;
    localparam int AM_W   = ZF + 5;

    localparam int K_FRAC = 24;
    localparam int KC_W   = 20;
    localparam int KS_W   = 24;
    localparam int KG_W   = 25;

    localparam int SQ_W   = 2 * AM_W - ZF;
    localparam int CUBE_W = SQ_W + AM_W - ZF;
    localparam int CT_W   = CUBE_W + KC_W - K_FRAC;
    localparam int U_W    = CT_W + 1;
    localparam int Z_W    = U_W;
    localparam int ZS_W   = AM_W + KG_W - K_FRAC;
    localparam int CDF_W  = ZF + 2;
    localparam int PROD_W = A_W + CDF_W;
    localparam int MAG_W  = PROD_W - ZF;

    localparam int PIPE_DEPTH = 10;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [KC_W-1:0] K_CUBIC = KC_W'(750193);
    localparam logic [KS_W-1:0] K_SQ2PI = KS_W'(13386282);
    localparam logic [KG_W-1:0] K_SIG   = KG_W'(28554822);

    localparam logic [XW-1:0]    X_CLAMP = XW'(16) << ZF;
    localparam logic [TAB_W-1:0] ONE_F   = TAB_W'(1) << ZF;
    localparam logic [CDF_W-1:0] ONE_CDF = CDF_W'(1) << ZF;

    localparam logic MODE_TANH    = 1'b0;
    localparam logic MODE_SIGMOID = 1'b1;

    typedef logic [TAB_W-1:0] tab_t [0:TABLE_SEGMENTS];

    // Restoring division, evaluated only while the tables are elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds tanh or sigmoid samples in Q.16 by stepping the tanh addition formula in Q30.
    function automatic tab_t build_tab(input logic want_sig);
        logic [63:0] one_q30;
        logic [63:0] s;
        logic [63:0] w;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] th;
        logic [63:0] t;
        tab_t        tanh_v;
        tab_t        sig_v;
        one_q30 = 64'd1 << 30;
        s       = (64'd1 << 32) >> SEG_BITS;
        w       = s << 1;
        e       = one_q30;
        term    = one_q30;
        for (int k = 1; k <= 24; k++)
        begin
            term = udiv64((term * w) >> 30, 64'(k));
            e    = e + term;
        end
        th = udiv64((e - one_q30) << 30, e + one_q30);
        t  = '0;
        for (int k = 0; k <= 2 * TABLE_SEGMENTS; k++)
        begin
            if (k[0] == 1'b0)
            begin
                tanh_v[k >> 1] = TAB_W'((t + (64'd1 << 13)) >> 14);
            end
            if (k <= TABLE_SEGMENTS)
            begin
                sig_v[k] = TAB_W'((one_q30 + t + (64'd1 << 14)) >> 15);
            end
            t = udiv64((t + th) << 30, one_q30 + ((t * th) >> 30));
        end
        for (int k = 1; k <= TABLE_SEGMENTS; k++)
        begin
            if (tanh_v[k] < tanh_v[k - 1])
            begin
                tanh_v[k] = tanh_v[k - 1];
            end
            if (sig_v[k] < sig_v[k - 1])
            begin
                sig_v[k] = sig_v[k - 1];
            end
        end
        if (want_sig)
        begin
            return sig_v;
        end
        return tanh_v;
    endfunction

    localparam tab_t TANH_TAB = build_tab(1'b0);
    localparam tab_t SIG_TAB  = build_tab(1'b1);

endpackage

[rtl/core/gelu_activation_unit_core.sv]
// Top level of the GELU activation core: a ten-stage pipeline over Q4.12 samples.
//
//  channel   direction  word                      handshake
//  sample    in         sample, last_in           sample_valid / sample_stall
//  result    out        activation, last_out      result_valid / result_stall
//  cfg       in         cfg_wdata (approx_mode)   cfg_we
//
// One word enters per cycle while sample_stall is low; the cubic term's
// multiplier chain and the table interpolation set the pipeline's depth.
// Reset clears the valid bits of every stage and selects the tanh form.
// A stall on the result side only holds stages that carry a word, so empty
// stages keep filling and sample_stall rises only when the whole pipe is full.
module gelu_activation_unit_core
    import gelu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [DATA_WIDTH-1:0] sample,
    input  logic                         last_in,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [DATA_WIDTH-1:0] activation,
    output logic                         last_out
);

    typedef struct packed {
        logic           neg;
        logic [A_W-1:0] mag;
        logic           last;
    } side_t;

    logic                  approx_mode_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] ready;
    side_t                 side_reg [0:PIPE_DEPTH-2];
    side_t                 side_next;

    logic [AM_W-1:0]       am1_reg, am2_reg, am3_reg, am_next;
    logic [SQ_W-1:0]       sq2_reg, sq_next;
    logic [Z_W-1:0]        zsig2_reg, zsig3_reg, zsig4_reg, zsig_next;
    logic [CUBE_W-1:0]     cube3_reg, cube_next;
    logic [U_W-1:0]        u4_reg, u_next;
    logic [Z_W-1:0]        z5_reg, z_next;
    logic                  sat6_reg, sat_next;
    logic [TAB_W-1:0]      lo6_reg, lo_next;
    logic [TAB_W-1:0]      diff6_reg, diff_next;
    logic [REM_SHIFT-1:0]  frac6_reg, frac_next;
    logic [TAB_W-1:0]      f7_reg, f_next;
    logic [CDF_W-1:0]      cdf8_reg, cdf_next;
    logic [MAG_W-1:0]      mag9_reg, mag_next;
    logic [DATA_WIDTH-1:0] act_reg, act_next;
    logic                  last_out_reg;

    logic [A_W-1:0]            a_in;
    logic [XW-1:0]             am_wide;
    logic [2*AM_W-1:0]         sq_prod;
    logic [AM_W+KG_W-1:0]      zs_prod;
    logic [SQ_W+AM_W-1:0]      cube_prod;
    logic [CUBE_W+KC_W-1:0]    ct_prod;
    logic [U_W+KS_W-1:0]       zt_prod;
    logic [IDX_W-1:0]          idx_lo, idx_hi;
    logic [TAB_W-1:0]          hi_val;
    logic [Z_LIMIT_BITS-1:0]   rem_full;
    logic [TAB_W+Z_LIMIT_BITS-1:0] ip_prod;
    logic [CDF_W-1:0]          f_ext;
    logic [PROD_W-1:0]         out_prod;
    logic [PROD_W:0]           out_round;
    logic [MAG_W-1:0]          lim, mag_c, mag_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            approx_mode_reg <= MODE_TANH;
        end
        else if (cfg_we)
        begin
            approx_mode_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        ready[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !result_stall;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? sample_valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        side_next.neg  = sample[DATA_WIDTH-1];
        a_in           = side_next.neg ? (~sample + 1'b1) : sample;
        side_next.mag  = a_in;
        side_next.last = last_in;
        am_wide        = (XW'(a_in) << AM_SHL) >> AM_SHR;
        am_next        = (am_wide > X_CLAMP) ? AM_W'(X_CLAMP) : AM_W'(am_wide);

        sq_prod   = {{AM_W{1'b0}}, am1_reg} * {{AM_W{1'b0}}, am1_reg};
        sq_next   = sq_prod[2*AM_W-1:ZF];
        zs_prod   = {{KG_W{1'b0}}, am1_reg} * {{AM_W{1'b0}}, K_SIG};
        zsig_next = Z_W'(zs_prod[AM_W+KG_W-1:K_FRAC]);

        cube_prod = {{AM_W{1'b0}}, sq2_reg} * {{SQ_W{1'b0}}, am2_reg};
        cube_next = cube_prod[SQ_W+AM_W-1:ZF];

        ct_prod = {{KC_W{1'b0}}, cube3_reg} * {{CUBE_W{1'b0}}, K_CUBIC};
        u_next  = U_W'(am3_reg) + U_W'(ct_prod[CUBE_W+KC_W-1:K_FRAC]);

        zt_prod = {{KS_W{1'b0}}, u4_reg} * {{U_W{1'b0}}, K_SQ2PI};
        z_next  = (approx_mode_reg == MODE_SIGMOID) ? zsig4_reg
                                                    : zt_prod[U_W+KS_W-1:K_FRAC];

        sat_next  = |z5_reg[Z_W-1:Z_LIMIT_BITS];
        idx_lo    = {1'b0, z5_reg[Z_LIMIT_BITS-1:REM_SHIFT]};
        idx_hi    = idx_lo + 1'b1;
        frac_next = z5_reg[REM_SHIFT-1:0];
        if (approx_mode_reg == MODE_SIGMOID)
        begin
            lo_next = SIG_TAB[idx_lo];
            hi_val  = SIG_TAB[idx_hi];
        end
        else
        begin
            lo_next = TANH_TAB[idx_lo];
            hi_val  = TANH_TAB[idx_hi];
        end
        diff_next = hi_val - lo_next;

        rem_full = {frac6_reg, {SEG_BITS{1'b0}}};
        ip_prod  = {{Z_LIMIT_BITS{1'b0}}, diff6_reg} * {{TAB_W{1'b0}}, rem_full};
        f_next   = sat6_reg ? ONE_F
                            : lo6_reg + ip_prod[TAB_W+Z_LIMIT_BITS-1:Z_LIMIT_BITS];

        f_ext = CDF_W'(f7_reg);
        if (approx_mode_reg == MODE_SIGMOID)
        begin
            cdf_next = side_reg[6].neg ? ((ONE_CDF - f_ext) << 1) : (f_ext << 1);
        end
        else
        begin
            cdf_next = side_reg[6].neg ? (ONE_CDF - f_ext) : (ONE_CDF + f_ext);
        end

        out_prod  = {{CDF_W{1'b0}}, side_reg[7].mag} * {{A_W{1'b0}}, cdf8_reg};
        out_round = {1'b0, out_prod} + ((PROD_W + 1)'(1) << ZF);
        mag_next  = out_round[PROD_W:ZF+1];

        lim      = side_reg[8].neg ? (MAG_W'(1) << (DATA_WIDTH - 1))
                                   : ((MAG_W'(1) << (DATA_WIDTH - 1)) - 1'b1);
        mag_c    = (mag9_reg > lim) ? lim : mag9_reg;
        mag_n    = ~mag_c + 1'b1;
        act_next = side_reg[8].neg ? mag_n[DATA_WIDTH-1:0] : mag_c[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            side_reg[0] <= side_next;
            am1_reg     <= am_next;
        end
        for (int i = 1; i < PIPE_DEPTH - 1; i++)
        begin
            if (ready[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
        if (ready[1])
        begin
            am2_reg   <= am1_reg;
            sq2_reg   <= sq_next;
            zsig2_reg <= zsig_next;
        end
        if (ready[2])
        begin
            am3_reg   <= am2_reg;
            cube3_reg <= cube_next;
            zsig3_reg <= zsig2_reg;
        end
        if (ready[3])
        begin
            u4_reg    <= u_next;
            zsig4_reg <= zsig3_reg;
        end
        if (ready[4])
        begin
            z5_reg <= z_next;
        end
        if (ready[5])
        begin
            sat6_reg  <= sat_next;
            lo6_reg   <= lo_next;
            diff6_reg <= diff_next;
            frac6_reg <= frac_next;
        end
        if (ready[6])
        begin
            f7_reg <= f_next;
        end
        if (ready[7])
        begin
            cdf8_reg <= cdf_next;
        end
        if (ready[8])
        begin
            mag9_reg <= mag_next;
        end
        if (ready[9])
        begin
            act_reg      <= act_next;
            last_out_reg <= side_reg[8].last;
        end
    end

    assign sample_stall = !ready[0];
    assign result_valid = valid_reg[PIPE_DEPTH-1];
    assign activation   = act_reg;
    assign last_out     = last_out_reg;

endmodule

[rtl/core/gelu_chk.sv]
// Port-level checker for the GELU core, bound to the top level.
module gelu_chk
    import gelu_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_we,
    input logic                         cfg_wdata,
    input logic                         sample_valid,
    input logic                         sample_stall,
    input logic signed [DATA_WIDTH-1:0] sample,
    input logic                         last_in,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic signed [DATA_WIDTH-1:0] activation,
    input logic                         last_out
);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign in_acc  = sample_valid && !sample_stall;
    assign out_acc = result_valid && !result_stall;

    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its word.
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(activation) && $stable(last_out))
        else $error("result word changed while stalled");

    // Every result belongs to a sample that was taken in and not yet delivered.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> cnt_reg != '0)
        else $error("result without an outstanding sample");

    // The pipeline never holds more words than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    // An empty pipeline always takes a sample.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> !sample_stall)
        else $error("sample stalled while the pipeline is empty");

endmodule

bind gelu_activation_unit_core gelu_chk u_gelu_chk (.*);

[dv/tb_top.sv]
// Testbench for the GELU activation core: predicts each result word and checks it.
`timescale 1ns / 1ps

module tb_top;
    import gelu_pkg::DATA_WIDTH;
    import gelu_pkg::FRAC_BITS;
    import gelu_pkg::TABLE_SEGMENTS;
    import gelu_pkg::MODE_TANH;
    import gelu_pkg::MODE_SIGMOID;

    localparam longint unsigned Q16_ONE    = 64'd1 << 16;
    localparam longint unsigned Q30_ONE    = 64'd1 << 30;
    localparam longint unsigned CUBIC_Q24  = 64'd750193;
    localparam longint unsigned SQRT2PI_Q24 = 64'd13386282;
    localparam longint unsigned SIGK_Q24   = 64'd28554822;
    localparam longint unsigned X_SAT_Q16  = 64'd16 << 16;
    localparam longint unsigned Z_END_Q16  = 64'd8 << 16;
    localparam int              Z_END_BITS = 19;
    localparam int              TAIL_CYCLES = 30;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] act;
        logic                         last;
    } gelu_word_t;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         cfg_we       = 1'b0;
    logic                         cfg_wdata    = 1'b0;
    logic                         sample_valid = 1'b0;
    logic                         sample_stall;
    logic signed [DATA_WIDTH-1:0] sample       = '0;
    logic                         last_in      = 1'b0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] activation;
    logic                         last_out;

    longint unsigned tanh_rom [0:TABLE_SEGMENTS];
    longint unsigned sigm_rom [0:TABLE_SEGMENTS];
    gelu_word_t      expected_words [$];
    logic            model_mode       = MODE_TANH;
    int              send_idle_pct    = 0;
    int              recv_stall_pct   = 0;
    int              mismatches       = 0;
    int              words_checked    = 0;
    int              words_sent       = 0;

    gelu_activation_unit_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .last_in      (last_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .activation   (activation),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // The tables step tanh by 1/16 with the addition formula in Q30.
    function automatic void fill_roms();
        longint unsigned step2;
        longint unsigned ex;
        longint unsigned term;
        longint unsigned th;
        longint unsigned t;
        step2 = ((64'd1 << 32) / TABLE_SEGMENTS) * 2;
        ex    = Q30_ONE;
        term  = Q30_ONE;
        t     = 0;
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * step2) >> 30) / longint'(k);
            ex   = ex + term;
        end
        th = ((ex - Q30_ONE) << 30) / (ex + Q30_ONE);
        for (int k = 0; k <= 2 * TABLE_SEGMENTS; k++)
        begin
            if (k % 2 == 0)
            begin
                tanh_rom[k / 2] = (t + (64'd1 << 13)) >> 14;
            end
            if (k <= TABLE_SEGMENTS)
            begin
                sigm_rom[k] = (Q30_ONE + t + (64'd1 << 14)) >> 15;
            end
            t = ((t + th) << 30) / (Q30_ONE + ((t * th) >> 30));
        end
        for (int k = 1; k <= TABLE_SEGMENTS; k++)
        begin
            if (tanh_rom[k] < tanh_rom[k - 1])
            begin
                tanh_rom[k] = tanh_rom[k - 1];
            end
            if (sigm_rom[k] < sigm_rom[k - 1])
            begin
                sigm_rom[k] = sigm_rom[k - 1];
            end
        end
    endfunction

    function automatic longint unsigned interp_rom(input logic use_sig, input longint unsigned z);
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned lo;
        longint unsigned hi;
        if (z >= Z_END_Q16)
        begin
            return Q16_ONE;
        end
        pos = z * TABLE_SEGMENTS;
        idx = pos >> Z_END_BITS;
        if (idx >= TABLE_SEGMENTS)
        begin
            return Q16_ONE;
        end
        rem = pos & ((64'd1 << Z_END_BITS) - 1);
        lo  = use_sig ? sigm_rom[idx] : tanh_rom[idx];
        hi  = use_sig ? sigm_rom[idx + 1] : tanh_rom[idx + 1];
        return lo + (((hi - lo) * rem) >> Z_END_BITS);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] gelu_of(
        input logic signed [DATA_WIDTH-1:0] x,
        input logic                         mode
    );
        longint unsigned a;
        longint unsigned am;
        longint unsigned cube;
        longint unsigned u;
        longint unsigned z;
        longint unsigned f;
        longint unsigned cdf;
        longint unsigned mag;
        longint unsigned lim;
        logic            neg;
        neg = x[DATA_WIDTH-1];
        a   = 64'(x[DATA_WIDTH-1:0]);
        if (neg)
        begin
            a = (~a + 1) & ((64'd1 << DATA_WIDTH) - 1);
        end
        if (FRAC_BITS <= 16)
        begin
            am = a << (16 - FRAC_BITS);
        end
        else
        begin
            am = a >> (FRAC_BITS - 16);
        end
        if (am > X_SAT_Q16)
        begin
            am = X_SAT_Q16;
        end
        if (mode == MODE_TANH)
        begin
            cube = (((am * am) >> 16) * am) >> 16;
            u    = am + ((cube * CUBIC_Q24) >> 24);
            z    = (u * SQRT2PI_Q24) >> 24;
            f    = interp_rom(1'b0, z);
            cdf  = neg ? (Q16_ONE - f) : (Q16_ONE + f);
        end
        else
        begin
            z   = (am * SIGK_Q24) >> 24;
            f   = interp_rom(1'b1, z);
            cdf = 2 * (neg ? (Q16_ONE - f) : f);
        end
        mag = (a * cdf + Q16_ONE) >> 17;
        lim = neg ? (64'd1 << (DATA_WIDTH - 1)) : ((64'd1 << (DATA_WIDTH - 1)) - 1);
        if (mag > lim)
        begin
            mag = lim;
        end
        return DATA_WIDTH'(neg ? (~mag + 1) : mag);
    endfunction

    task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
        $display("MISMATCH at %0t: %s expected %0d, got %0d", $realtime, what, want_v, got_v);
        mismatches++;
    endtask

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input logic signed [DATA_WIDTH-1:0] x, input logic last);
        gelu_word_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= x;
        last_in      <= last;
        do
            @(posedge clk);
        while (sample_stall);
        want.act  = gelu_of(x, model_mode);
        want.last = last;
        expected_words.push_back(want);
        words_sent++;
    endtask

    task automatic wait_until_empty();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    task automatic set_mode(input logic mode);
        wait_until_empty();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we     <= 1'b0;
        model_mode  = mode;
    endtask

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_words
        gelu_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word, activation", 0, activation);
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (activation !== want.act)
                begin
                    report_mismatch("activation", want.act, activation);
                end
                if (last_out !== want.last)
                begin
                    report_mismatch("last_out", want.last, last_out);
                end
            end
        end
    end

    task automatic test_corner_samples(input logic mode);
        int corner_values [13];
        corner_values = '{0, 1, -1, 32767, -32768, 4096, -4096, 8192, -12288,
                          16384, -16384, 21845, -21846};
        if (mode != model_mode)
        begin
            set_mode(mode);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 13; i++)
        begin
            send_word(DATA_WIDTH'(corner_values[i]), i[0]);
        end
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            return DATA_WIDTH'($urandom_range(32767) - 16384);
        end
        if (pick < 85)
        begin
            return DATA_WIDTH'($urandom);
        end
        if (pick < 92)
        begin
            return DATA_WIDTH'(32767 - $urandom_range(255));
        end
        return DATA_WIDTH'(-32768 + $urandom_range(255));
    endfunction

    task automatic test_random_stream(input logic mode, input int idle_pct,
                                      input int stall_pct, input int count);
        set_mode(mode);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            send_word(pick_sample(), ($urandom_range(7) == 0));
        end
    endtask

    task automatic test_pause_until_empty();
        set_mode(MODE_SIGMOID);
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int burst = 0; burst < 5; burst++)
        begin
            for (int i = 0; i < 20; i++)
            begin
                send_word(pick_sample(), (i == 19));
            end
            wait_until_empty();
        end
    endtask

    initial
    begin
        fill_roms();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_samples(MODE_TANH);
        test_corner_samples(MODE_SIGMOID);
        test_random_stream(MODE_TANH,     0,  0, 240);
        test_random_stream(MODE_SIGMOID,  0,  0, 240);
        test_random_stream(MODE_TANH,    59,  0, 240);
        test_random_stream(MODE_SIGMOID, 59,  0, 240);
        test_random_stream(MODE_TANH,     0, 59, 240);
        test_random_stream(MODE_SIGMOID,  0, 59, 240);
        test_random_stream(MODE_TANH,     9,  9, 240);
        test_random_stream(MODE_SIGMOID,  9,  9, 240);
        test_pause_until_empty();

        wait_until_empty();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d words and checked %0d results in both the tanh and sigmoid forms,",
                 words_sent, words_checked);
        $display("under free flow, sender gaps, receiver stalls and both at once.");
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[gelu_activation_unit_core.f]
rtl/core/gelu_pkg.sv
rtl/core/gelu_activation_unit_core.sv
rtl/core/gelu_chk.sv
dv/tb_top.sv
